// File: sv/dafs_pkg.sv
// types and constants shared by the dram address field splitter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dafs_pkg;

	// result field widths
	localparam int unsigned RANK_W = 8;
	localparam int unsigned BANK_W = 8;
	localparam int unsigned ROW_W = 24;
	localparam int unsigned COL_W = 16;

	// bit position within the address: start plus every field width fits below 128
	localparam int unsigned POS_W = 7;
	// width of one field as configured
	localparam int unsigned FW_W = 5;
	// count of low column bits, line offset minus bus offset
	localparam int unsigned LOWCOL_W = 4;

	// configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 5;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIELD_ORDER      = 3'd0,
		CFG_RANK_BITS        = 3'd1,
		CFG_BANK_BITS        = 3'd2,
		CFG_ROW_BITS         = 3'd3,
		CFG_COLUMN_BITS      = 3'd4,
		CFG_BUS_OFFSET_BITS  = 3'd5,
		CFG_CHANNEL_BITS     = 3'd6,
		CFG_LINE_OFFSET_BITS = 3'd7
	} cfg_index_t;

	// field orders, named by their most significant fields
	typedef enum logic [2:0] {
		ORD_BANK_COLHI     = 3'd0, // bank:colhigh:row:rank:chan:collow:byte
		ORD_COLHI_ROW      = 3'd1, // colhigh:row:rank:bank:chan:collow:byte
		ORD_RANK_BANK      = 3'd2, // rank:bank:row:colhigh:chan:collow:byte
		ORD_ROW_CHAN       = 3'd3, // row:chan:bank:rank:col:byte
		ORD_ROW_BANK_CHAN  = 3'd4, // row:bank:rank:chan:col:byte
		ORD_ROW_BANK_COLHI = 3'd5, // row:bank:rank:colhigh:chan:collow:byte
		ORD_ROW_COLHI      = 3'd6, // row:colhigh:bank:rank:chan:collow:byte
		ORD_CHAN_TOP       = 3'd7  // chan:row:bank:rank:col:byte
	} order_t;

	// where one field sits in the address
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [FW_W-1:0]  width;
	} field_sel_t;

endpackage

`default_nettype wire

// File: sv/dafs_if.sv
// request channels of the dram address field splitter: address in, coordinates out
// depends on dafs_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dafs_req_if #(
	parameter int unsigned ADDRESS_WIDTH = 48
);
	logic                     valid;
	logic                     ready;
	logic [ADDRESS_WIDTH-1:0] byte_address;

	modport source (output valid, output byte_address, input ready);
	modport sink (input valid, input byte_address, output ready);
endinterface

interface dafs_resp_if;
	logic                         valid;
	logic                         ready;
	logic [dafs_pkg::RANK_W-1:0]  rank_out;
	logic [dafs_pkg::BANK_W-1:0]  bank_out;
	logic [dafs_pkg::ROW_W-1:0]   row_out;
	logic [dafs_pkg::COL_W-1:0]   column_out;

	modport source (output valid, output rank_out, output bank_out, output row_out,
		output column_out, input ready);
	modport sink (input valid, input rank_out, input bank_out, input row_out,
		input column_out, output ready);
endinterface

`default_nettype wire

// File: sv/dafs_field_extract.sv
// takes one field of a given position and width out of an address
// depends on dafs_pkg
`timescale 1ns / 1ps
`default_nettype none

module dafs_field_extract #(
	parameter int unsigned ADDRESS_WIDTH = 48,
	parameter int unsigned FIELD_W = 24
) (
	input  wire logic [ADDRESS_WIDTH-1:0] addr,
	input  wire dafs_pkg::field_sel_t     sel,
	output logic [FIELD_W-1:0]            field
);

	localparam int unsigned SPAN_W = (ADDRESS_WIDTH > FIELD_W) ? ADDRESS_WIDTH : FIELD_W;

	logic [SPAN_W-1:0]  span;
	logic [SPAN_W-1:0]  shifted;
	logic [FIELD_W-1:0] keep;

	// bits past the top of the address shift in as zero
	assign span = SPAN_W'(addr);
	assign shifted = span >> sel.pos;

	// keep only the configured width
	always_comb begin
		for (int i = 0; i < FIELD_W; i++) begin
			keep[i] = ($unsigned(i) < 32'(sel.width));
		end
	end

	assign field = shifted[FIELD_W-1:0] & keep;

endmodule

`default_nettype wire

// File: sv/dram_address_field_splitter.sv
// A request passes four register stages before its result is valid.
// Throughput: one request per cycle while the result side is ready; four register stages (field
// bounds, field positions, field extraction, column shift) each take a new request every cycle.
// A stalled stage holds; a stage behind a bubble keeps moving.
// Reset clears all stage valid bits and loads the configuration defaults.
// top level of the dram address field splitter; depends on dafs_pkg, dafs_if, dafs_field_extract
`timescale 1ns / 1ps
`default_nettype none

module dram_address_field_splitter #(
	parameter int unsigned ADDRESS_WIDTH = 48
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dafs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dafs_pkg::CFG_DATA_W-1:0] cfg_data,
	dafs_req_if.sink                            req,
	dafs_resp_if.source                         resp
);

	localparam int unsigned POS_W = dafs_pkg::POS_W;
	localparam int unsigned FW_W = dafs_pkg::FW_W;
	localparam int unsigned LOWCOL_W = dafs_pkg::LOWCOL_W;
	localparam int unsigned COL_W = dafs_pkg::COL_W;

	// configuration registers
	dafs_pkg::order_t field_order_q;
	logic [3:0]       rank_bits_q;
	logic [3:0]       bank_bits_q;
	logic [4:0]       row_bits_q;
	logic [4:0]       column_bits_q;
	logic [2:0]       bus_offset_bits_q;
	logic [2:0]       channel_bits_q;
	logic [3:0]       line_offset_bits_q;

	// stage enables
	logic en1, en2, en3, en4;

	// stage 1: address, start position, column widths
	logic                     v_s1;
	logic [ADDRESS_WIDTH-1:0] addr_s1;
	dafs_pkg::order_t         order_s1;
	logic [POS_W-1:0]         start_s1;
	logic [LOWCOL_W-1:0]      lowcol_s1;
	logic [FW_W-1:0]          hiw_s1;

	// stage 2: field positions
	logic                     v_s2;
	logic [ADDRESS_WIDTH-1:0] addr_s2;
	dafs_pkg::field_sel_t     rank_sel_s2, bank_sel_s2, row_sel_s2, col_sel_s2;
	logic [LOWCOL_W-1:0]      shift_s2;

	// stage 3: extracted fields
	logic                        v_s3;
	logic [dafs_pkg::RANK_W-1:0] rank_s3;
	logic [dafs_pkg::BANK_W-1:0] bank_s3;
	logic [dafs_pkg::ROW_W-1:0]  row_s3;
	logic [COL_W-1:0]            col_s3;
	logic [LOWCOL_W-1:0]         shift_s3;

	// stage 4: output register
	logic                        v_s4;
	logic [dafs_pkg::RANK_W-1:0] rank_s4;
	logic [dafs_pkg::BANK_W-1:0] bank_s4;
	logic [dafs_pkg::ROW_W-1:0]  row_s4;
	logic [COL_W-1:0]            col_s4;
	logic [LOWCOL_W-1:0]         shift_s4;

	// combinational results per stage
	logic [POS_W-1:0]            start_d;
	logic [LOWCOL_W-1:0]         lowcol_d;
	logic [FW_W-1:0]             hiw_d;
	dafs_pkg::field_sel_t        rank_sel_d, bank_sel_d, row_sel_d, col_sel_d;
	logic [LOWCOL_W-1:0]         shift_d;
	logic [dafs_pkg::RANK_W-1:0] rank_d;
	logic [dafs_pkg::BANK_W-1:0] bank_d;
	logic [dafs_pkg::ROW_W-1:0]  row_d;
	logic [COL_W-1:0]            col_d;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_order_q      <= dafs_pkg::ORD_BANK_COLHI;
			rank_bits_q        <= 4'd1;
			bank_bits_q        <= 4'd3;
			row_bits_q         <= 5'd14;
			column_bits_q      <= 5'd10;
			bus_offset_bits_q  <= 3'd3;
			channel_bits_q     <= 3'd0;
			line_offset_bits_q <= 4'd6;
		end else if (cfg_we) begin
			case (cfg_index)
				dafs_pkg::CFG_FIELD_ORDER:      field_order_q <= dafs_pkg::order_t'(cfg_data[2:0]);
				dafs_pkg::CFG_RANK_BITS:        rank_bits_q <= cfg_data[3:0];
				dafs_pkg::CFG_BANK_BITS:        bank_bits_q <= cfg_data[3:0];
				dafs_pkg::CFG_ROW_BITS:         row_bits_q <= cfg_data[4:0];
				dafs_pkg::CFG_COLUMN_BITS:      column_bits_q <= cfg_data[4:0];
				dafs_pkg::CFG_BUS_OFFSET_BITS:  bus_offset_bits_q <= cfg_data[2:0];
				dafs_pkg::CFG_CHANNEL_BITS:     channel_bits_q <= cfg_data[2:0];
				dafs_pkg::CFG_LINE_OFFSET_BITS: line_offset_bits_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// a stage moves when it is empty or the stage after it moves
	assign en4 = !v_s4 || resp.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req.ready = en1;

	// stage 1 logic: start position and saturated column widths
	always_comb begin
		if (field_order_q == dafs_pkg::ORD_ROW_CHAN || field_order_q == dafs_pkg::ORD_ROW_BANK_CHAN
				|| field_order_q == dafs_pkg::ORD_CHAN_TOP) begin
			start_d = POS_W'(bus_offset_bits_q);
		end else begin
			start_d = POS_W'(channel_bits_q) + POS_W'(line_offset_bits_q);
		end
		lowcol_d = (line_offset_bits_q > LOWCOL_W'(bus_offset_bits_q))
			? line_offset_bits_q - LOWCOL_W'(bus_offset_bits_q) : '0;
		hiw_d = (column_bits_q > FW_W'(lowcol_d)) ? column_bits_q - FW_W'(lowcol_d) : '0;
	end

	// stage 2 logic: position of every field in the chosen order
	always_comb begin
		logic [POS_W-1:0] s, r, b, w, c, h, ch;
		s  = start_s1;
		r  = POS_W'(rank_bits_q);
		b  = POS_W'(bank_bits_q);
		w  = POS_W'(row_bits_q);
		c  = POS_W'(column_bits_q);
		h  = POS_W'(hiw_s1);
		ch = POS_W'(channel_bits_q);
		rank_sel_d.width = FW_W'(rank_bits_q);
		bank_sel_d.width = FW_W'(bank_bits_q);
		row_sel_d.width  = row_bits_q;
		col_sel_d.width  = hiw_s1;
		shift_d = lowcol_s1;
		case (order_s1)
			dafs_pkg::ORD_BANK_COLHI: begin
				rank_sel_d.pos = s;
				row_sel_d.pos  = s + r;
				col_sel_d.pos  = s + r + w;
				bank_sel_d.pos = s + r + w + h;
			end
			dafs_pkg::ORD_COLHI_ROW: begin
				bank_sel_d.pos = s;
				rank_sel_d.pos = s + b;
				row_sel_d.pos  = s + b + r;
				col_sel_d.pos  = s + b + r + w;
			end
			dafs_pkg::ORD_RANK_BANK: begin
				col_sel_d.pos  = s;
				row_sel_d.pos  = s + h;
				bank_sel_d.pos = s + h + w;
				rank_sel_d.pos = s + h + w + b;
			end
			dafs_pkg::ORD_ROW_CHAN: begin
				col_sel_d.pos   = s;
				col_sel_d.width = column_bits_q;
				shift_d         = '0;
				rank_sel_d.pos  = s + c;
				bank_sel_d.pos  = s + c + r;
				row_sel_d.pos   = s + c + r + b + ch;
			end
			dafs_pkg::ORD_ROW_BANK_CHAN: begin
				col_sel_d.pos   = s;
				col_sel_d.width = column_bits_q;
				shift_d         = '0;
				rank_sel_d.pos  = s + c + ch;
				bank_sel_d.pos  = s + c + ch + r;
				row_sel_d.pos   = s + c + ch + r + b;
			end
			dafs_pkg::ORD_ROW_BANK_COLHI: begin
				col_sel_d.pos  = s;
				rank_sel_d.pos = s + h;
				bank_sel_d.pos = s + h + r;
				row_sel_d.pos  = s + h + r + b;
			end
			dafs_pkg::ORD_ROW_COLHI: begin
				rank_sel_d.pos = s;
				bank_sel_d.pos = s + r;
				col_sel_d.pos  = s + r + b;
				row_sel_d.pos  = s + r + b + h;
			end
			default: begin
				// channel above every field
				col_sel_d.pos   = s;
				col_sel_d.width = column_bits_q;
				shift_d         = '0;
				rank_sel_d.pos  = s + c;
				bank_sel_d.pos  = s + c + r;
				row_sel_d.pos   = s + c + r + b;
			end
		endcase
	end

	// stage 3 logic: field extraction
	dafs_field_extract #(.ADDRESS_WIDTH(ADDRESS_WIDTH), .FIELD_W(dafs_pkg::RANK_W)) u_rank (
		.addr(addr_s2), .sel(rank_sel_s2), .field(rank_d)
	);
	dafs_field_extract #(.ADDRESS_WIDTH(ADDRESS_WIDTH), .FIELD_W(dafs_pkg::BANK_W)) u_bank (
		.addr(addr_s2), .sel(bank_sel_s2), .field(bank_d)
	);
	dafs_field_extract #(.ADDRESS_WIDTH(ADDRESS_WIDTH), .FIELD_W(dafs_pkg::ROW_W)) u_row (
		.addr(addr_s2), .sel(row_sel_s2), .field(row_d)
	);
	dafs_field_extract #(.ADDRESS_WIDTH(ADDRESS_WIDTH), .FIELD_W(COL_W)) u_col (
		.addr(addr_s2), .sel(col_sel_s2), .field(col_d)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en1) begin
			addr_s1   <= ADDRESS_WIDTH'(req.byte_address);
			order_s1  <= field_order_q;
			start_s1  <= start_d;
			lowcol_s1 <= lowcol_d;
			hiw_s1    <= hiw_d;
		end
		if (en2) begin
			addr_s2     <= addr_s1;
			rank_sel_s2 <= rank_sel_d;
			bank_sel_s2 <= bank_sel_d;
			row_sel_s2  <= row_sel_d;
			col_sel_s2  <= col_sel_d;
			shift_s2    <= shift_d;
		end
		if (en3) begin
			rank_s3  <= rank_d;
			bank_s3  <= bank_d;
			row_s3   <= row_d;
			col_s3   <= col_d;
			shift_s3 <= shift_s2;
		end
		if (en4) begin
			rank_s4  <= rank_s3;
			bank_s4  <= bank_s3;
			row_s4   <= row_s3;
			// high column bits move up, low column bits read as zero
			col_s4   <= col_s3 << shift_s3;
			shift_s4 <= shift_s3;
		end
	end

	// result channel
	assign resp.valid      = v_s4;
	assign resp.rank_out   = rank_s4;
	assign resp.bank_out   = bank_s4;
	assign resp.row_out    = row_s4;
	assign resp.column_out = col_s4;

`ifndef NO_ASSERTIONS
	// backpressure reaches the input only with every stage full
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input blocked with a free stage");

	// low column bits of a cache-line order are zero
	a_low_column_zero: assert property (@(posedge clk) disable iff (!arst_n)
		resp.valid |-> ((resp.column_out & ((COL_W'(1) << shift_s4) - COL_W'(1))) == '0))
		else $error("low column bits not zero");

	// a held stage 1 keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en2) |=> (v_s1 && $stable(addr_s1) && $stable(start_s1)))
		else $error("stage 1 lost its request under stall");

	// a stage 3 request that is not taken is not dropped
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en4) |=> (v_s3 && $stable(row_s3) && $stable(col_s3)))
		else $error("stage 3 lost its request under stall");
`endif

endmodule

`default_nettype wire

// File: test/tb_dram_address_field_splitter.sv
// testbench for the dram address field splitter: random and directed addresses under many
// field orders and widths, every result checked against a predictor in the scoreboard
// depends on dafs_pkg, dafs_if and the block itself
`timescale 1ns / 1ps

// dram coordinates of one result
typedef struct {
	logic [dafs_pkg::RANK_W-1:0] rank;
	logic [dafs_pkg::BANK_W-1:0] bank;
	logic [dafs_pkg::ROW_W-1:0]  row;
	logic [dafs_pkg::COL_W-1:0]  column;
} coord_t;

// predicts the split of each accepted request and checks results in order
class address_split_scoreboard;
	dafs_pkg::order_t order_sel;
	int unsigned      rank_w, bank_w, row_w, column_w, bus_w, chan_w, line_w;
	coord_t           expected_coords[$];
	int unsigned      failures;

	function new();
		order_sel = dafs_pkg::ORD_BANK_COLHI;
		rank_w    = 1;
		bank_w    = 3;
		row_w     = 14;
		column_w  = 10;
		bus_w     = 3;
		chan_w    = 0;
		line_w    = 6;
		failures  = 0;
	endfunction

	// register write, only the register's own width is kept
	function void write_reg(dafs_pkg::cfg_index_t idx, logic [dafs_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			dafs_pkg::CFG_FIELD_ORDER:      order_sel = dafs_pkg::order_t'(data[2:0]);
			dafs_pkg::CFG_RANK_BITS:        rank_w = 32'(data[3:0]);
			dafs_pkg::CFG_BANK_BITS:        bank_w = 32'(data[3:0]);
			dafs_pkg::CFG_ROW_BITS:         row_w = 32'(data[4:0]);
			dafs_pkg::CFG_COLUMN_BITS:      column_w = 32'(data[4:0]);
			dafs_pkg::CFG_BUS_OFFSET_BITS:  bus_w = 32'(data[2:0]);
			dafs_pkg::CFG_CHANNEL_BITS:     chan_w = 32'(data[2:0]);
			dafs_pkg::CFG_LINE_OFFSET_BITS: line_w = 32'(data[3:0]);
			default: ;
		endcase
	endfunction

	// w bits of the address from pos up, zero past bit 63
	function logic [63:0] field_at(logic [63:0] a, int unsigned pos, int unsigned w);
		logic [63:0] mask;
		mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
		if (pos >= 64)
			return '0;
		return (a >> pos) & mask;
	endfunction

	function coord_t split_address(logic [47:0] addr);
		logic [63:0] a, rk, bk, rw, cl;
		int unsigned lowcol, hiw, pos;
		coord_t c;
		a = {16'd0, addr};
		// column bits below the line offset read as zero in the cache-line orders
		lowcol = (line_w > bus_w) ? line_w - bus_w : 0;
		hiw = (column_w > lowcol) ? column_w - lowcol : 0;
		if (order_sel == dafs_pkg::ORD_ROW_CHAN || order_sel == dafs_pkg::ORD_ROW_BANK_CHAN ||
				order_sel == dafs_pkg::ORD_CHAN_TOP)
			pos = bus_w;
		else
			pos = chan_w + line_w;
		case (order_sel)
			dafs_pkg::ORD_BANK_COLHI: begin
				rk = field_at(a, pos, rank_w); pos += rank_w;
				rw = field_at(a, pos, row_w); pos += row_w;
				cl = field_at(a, pos, hiw) << lowcol; pos += hiw;
				bk = field_at(a, pos, bank_w);
			end
			dafs_pkg::ORD_COLHI_ROW: begin
				bk = field_at(a, pos, bank_w); pos += bank_w;
				rk = field_at(a, pos, rank_w); pos += rank_w;
				rw = field_at(a, pos, row_w); pos += row_w;
				cl = field_at(a, pos, hiw) << lowcol;
			end
			dafs_pkg::ORD_RANK_BANK: begin
				cl = field_at(a, pos, hiw) << lowcol; pos += hiw;
				rw = field_at(a, pos, row_w); pos += row_w;
				bk = field_at(a, pos, bank_w); pos += bank_w;
				rk = field_at(a, pos, rank_w);
			end
			dafs_pkg::ORD_ROW_CHAN: begin
				cl = field_at(a, pos, column_w); pos += column_w;
				rk = field_at(a, pos, rank_w); pos += rank_w;
				bk = field_at(a, pos, bank_w); pos += bank_w + chan_w;
				rw = field_at(a, pos, row_w);
			end
			dafs_pkg::ORD_ROW_BANK_CHAN: begin
				cl = field_at(a, pos, column_w); pos += column_w + chan_w;
				rk = field_at(a, pos, rank_w); pos += rank_w;
				bk = field_at(a, pos, bank_w); pos += bank_w;
				rw = field_at(a, pos, row_w);
			end
			dafs_pkg::ORD_ROW_BANK_COLHI: begin
				cl = field_at(a, pos, hiw) << lowcol; pos += hiw;
				rk = field_at(a, pos, rank_w); pos += rank_w;
				bk = field_at(a, pos, bank_w); pos += bank_w;
				rw = field_at(a, pos, row_w);
			end
			dafs_pkg::ORD_ROW_COLHI: begin
				rk = field_at(a, pos, rank_w); pos += rank_w;
				bk = field_at(a, pos, bank_w); pos += bank_w;
				cl = field_at(a, pos, hiw) << lowcol; pos += hiw;
				rw = field_at(a, pos, row_w);
			end
			default: begin
				cl = field_at(a, pos, column_w); pos += column_w;
				rk = field_at(a, pos, rank_w); pos += rank_w;
				bk = field_at(a, pos, bank_w); pos += bank_w;
				rw = field_at(a, pos, row_w);
			end
		endcase
		c.rank   = rk[dafs_pkg::RANK_W-1:0];
		c.bank   = bk[dafs_pkg::BANK_W-1:0];
		c.row    = rw[dafs_pkg::ROW_W-1:0];
		c.column = cl[dafs_pkg::COL_W-1:0];
		return c;
	endfunction

	function void note_request(logic [47:0] addr);
		expected_coords.insert(expected_coords.size(), split_address(addr));
	endfunction

	function void check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s expected %0h actual %0h", $time, name, exp_v, act_v);
			failures++;
		end
	endfunction

	function void check_result(coord_t seen);
		coord_t want;
		if (expected_coords.size() == 0) begin
			$display("%0t ns: result with no request pending, expected none actual %0h %0h %0h %0h",
				$time, seen.rank, seen.bank, seen.row, seen.column);
			failures++;
			return;
		end
		want = expected_coords.pop_front();
		check_field("rank", 24'(want.rank), 24'(seen.rank));
		check_field("bank", 24'(want.bank), 24'(seen.bank));
		check_field("row", want.row, seen.row);
		check_field("column", 24'(want.column), 24'(seen.column));
	endfunction

	function int unsigned pending();
		return expected_coords.size();
	endfunction
endclass

module tb_dram_address_field_splitter;

	localparam int unsigned LATENCY = 3;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	dafs_pkg::cfg_index_t            cfg_index;
	logic [dafs_pkg::CFG_DATA_W-1:0] cfg_data;
	bit                              idle_on = 1'b1;

	address_split_scoreboard sb;

	dafs_req_if #(.ADDRESS_WIDTH(48)) addr_ch ();
	dafs_resp_if coord_ch ();

	dram_address_field_splitter #(
		.ADDRESS_WIDTH(48)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(addr_ch),
		.resp(coord_ch)
	);

	// clock, 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// one request, after a random idle gap while idle_on is set
	task automatic send_address(input logic [47:0] addr);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			addr_ch.valid <= 1'b0;
		end
		@(negedge clk);
		addr_ch.valid <= 1'b1;
		addr_ch.byte_address <= addr;
		do @(posedge clk); while (addr_ch.ready !== 1'b1);
		sb.note_request(addr);
	endtask

	// stop requests and let the pipeline empty
	task automatic wait_idle();
		@(negedge clk);
		addr_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input dafs_pkg::cfg_index_t idx,
			input logic [dafs_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic apply_setting(input int unsigned order, input int unsigned rank,
			input int unsigned bank, input int unsigned row, input int unsigned col,
			input int unsigned bus, input int unsigned chan, input int unsigned line);
		wait_idle();
		write_reg(dafs_pkg::CFG_FIELD_ORDER, dafs_pkg::CFG_DATA_W'(order));
		write_reg(dafs_pkg::CFG_RANK_BITS, dafs_pkg::CFG_DATA_W'(rank));
		write_reg(dafs_pkg::CFG_BANK_BITS, dafs_pkg::CFG_DATA_W'(bank));
		write_reg(dafs_pkg::CFG_ROW_BITS, dafs_pkg::CFG_DATA_W'(row));
		write_reg(dafs_pkg::CFG_COLUMN_BITS, dafs_pkg::CFG_DATA_W'(col));
		write_reg(dafs_pkg::CFG_BUS_OFFSET_BITS, dafs_pkg::CFG_DATA_W'(bus));
		write_reg(dafs_pkg::CFG_CHANNEL_BITS, dafs_pkg::CFG_DATA_W'(chan));
		write_reg(dafs_pkg::CFG_LINE_OFFSET_BITS, dafs_pkg::CFG_DATA_W'(line));
	endtask

	// either a sensible value up to hi or any raw register data
	function automatic int unsigned draw_value(bit raw, int unsigned hi);
		return raw ? $urandom_range(0, 31) : $urandom_range(0, hi);
	endfunction

	task automatic random_setting();
		bit raw;
		raw = ($urandom_range(0, 3) == 0);
		apply_setting(draw_value(raw, 7), draw_value(raw, 8), draw_value(raw, 8),
			draw_value(raw, 24), draw_value(raw, 16), draw_value(raw, 6),
			draw_value(raw, 4), draw_value(raw, 10));
	endtask

	function automatic logic [47:0] random_address();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 48'd1 << $urandom_range(0, 47);
			3: return ~(48'd1 << $urandom_range(0, 47));
			default: return r[47:0];
		endcase
	endfunction

	// stimulus
	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = dafs_pkg::CFG_FIELD_ORDER;
		cfg_data = '0;
		addr_ch.valid = 1'b0;
		addr_ch.byte_address = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// reset widths, extreme addresses
		send_address('0);
		send_address('1);
		send_address(48'hAAAA_AAAA_AAAA);
		send_address(48'h5555_5555_5555);

		// every field order at reset widths
		for (int o = 1; o < 8; o++) begin
			wait_idle();
			write_reg(dafs_pkg::CFG_FIELD_ORDER, dafs_pkg::CFG_DATA_W'(o));
			send_address('1);
			send_address(random_address());
		end

		// bus offset above line offset: no low column bits
		apply_setting(int'(dafs_pkg::ORD_BANK_COLHI), 2, 3, 14, 10, 6, 1, 2);
		send_address('1);
		// column narrower than the low column bits: column reads zero
		apply_setting(int'(dafs_pkg::ORD_ROW_BANK_COLHI), 1, 3, 14, 2, 0, 0, 10);
		send_address('1);
		// fields wider than outputs, column shifted past 16 bits, fields past bit 63
		apply_setting(int'(dafs_pkg::ORD_BANK_COLHI), 15, 15, 31, 31, 0, 7, 15);
		send_address('1);
		apply_setting(int'(dafs_pkg::ORD_CHAN_TOP), 15, 15, 31, 31, 7, 7, 15);
		send_address('1);

		// random phases, extremes first
		for (int phase = 0; phase < 16; phase++) begin
			case (phase)
				0: apply_setting($urandom_range(0, 7), 0, 0, 0, 0, 0, 0, 0);
				1: apply_setting($urandom_range(0, 7), 8, 8, 24, 16, 6, 4, 10);
				2: apply_setting(31, 31, 31, 31, 31, 31, 31, 31);
				default: random_setting();
			endcase
			idle_on = ($urandom_range(0, 3) != 0);
			repeat (25) send_address(random_address());
		end

		wait_idle();
		if (sb.failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// result side, random stalls
	initial begin
		int unsigned gap;
		coord_t seen;
		coord_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = idle_on ? $urandom_range(0, 3) : 0;
			repeat (gap) begin
				@(negedge clk);
				coord_ch.ready <= 1'b0;
			end
			@(negedge clk);
			coord_ch.ready <= 1'b1;
			do @(posedge clk); while (coord_ch.valid !== 1'b1);
			seen.rank   = coord_ch.rank_out;
			seen.bank   = coord_ch.bank_out;
			seen.row    = coord_ch.row_out;
			seen.column = coord_ch.column_out;
			sb.check_result(seen);
		end
	end

	// run limit
	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
